@@ design/mfnp_pkg.sv @@
// ----------------------------------------------------------------------------
// mfnp_pkg
// Shared constants for the MIDI file note pairing parser.
// ----------------------------------------------------------------------------
package mfnp_pkg;

  // default sizes
  localparam int unsigned MaxEventsDef = 4096;
  localparam int unsigned NumKeysDef   = 256;
  localparam int unsigned NumChanRows  = 17;

  // config reset and status byte bounds
  localparam logic [15:0] TicksPerBeatRst = 16'd120;
  localparam logic [7:0]  StatusRelLo     = 8'd128;
  localparam logic [7:0]  StatusPressLo   = 8'd144;
  localparam logic [7:0]  StatusHi        = 8'd160;

  // quotient width of the serial divider
  localparam int unsigned DivBits = 32;

  // result kinds
  localparam logic [1:0] KindStart   = 2'd0;
  localparam logic [1:0] KindLength  = 2'd1;
  localparam logic [1:0] KindNoPress = 2'd2;
  localparam logic [1:0] KindFull    = 2'd3;

  // parse phases
  localparam logic [3:0] PhHdrSkip = 4'd0;
  localparam logic [3:0] PhNtrk    = 4'd1;
  localparam logic [3:0] PhTbase   = 4'd2;
  localparam logic [3:0] PhTrkSkip = 4'd3;
  localparam logic [3:0] PhTrkLen  = 4'd4;
  localparam logic [3:0] PhDelta   = 4'd5;
  localparam logic [3:0] PhStatus  = 4'd6;
  localparam logic [3:0] PhKey     = 4'd7;
  localparam logic [3:0] PhVel     = 4'd8;
  localparam logic [3:0] PhDone    = 4'd9;

  // event sequencer states
  localparam logic [1:0] SqIdle = 2'd0;
  localparam logic [1:0] SqMul  = 2'd1;
  localparam logic [1:0] SqDiv  = 2'd2;
  localparam logic [1:0] SqFin  = 2'd3;

endpackage

@@ design/midi_file_note_pairing_parser_core.sv @@
// ----------------------------------------------------------------------------
// midi_file_note_pairing_parser_core
// Parses a MIDI file byte stream and pairs note presses with releases.
// ----------------------------------------------------------------------------
// Header, length, delta, status and key bytes are handled on the accept
// alone. The velocity byte of a note event also runs the event sequencer:
// the accept, the 32x16 scale multiply, the bit-serial divide by the file
// timebase, and a finish step that updates the pairing table and event
// store memories; the finish waits while the previous result beat is not
// taken. After reset a clearing pass over all 17*NUM_KEYS entries (4352 at
// the default) zeroes the pairing table before the first byte is accepted.
module midi_file_note_pairing_parser_core
  import mfnp_pkg::*;
#(
  parameter int unsigned MAX_EVENTS = MaxEventsDef,
  parameter int unsigned NUM_KEYS   = NumKeysDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,       // output_ticks_per_beat
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,      // file_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,      // event_index, position, interval,
                                          // note_length, channel, key, velocity
  output logic [1:0]   m_axis_tuser       // kind
);

  localparam int unsigned IW    = $clog2(MAX_EVENTS);
  localparam int unsigned PDEP  = NumChanRows * NUM_KEYS;
  localparam int unsigned PAW   = $clog2(PDEP);
  localparam int unsigned CNTW  = $clog2(DivBits);

  // control registers
  logic [15:0]    scale_q;
  logic [3:0]     phase_q;
  logic [3:0]     pcnt_q;
  logic [15:0]    tracks_q, tbase_q;
  logic [31:0]    tlen_q, used_q, delta_q, abs_q, last_q;
  logic [7:0]     status_q, key_q, vel_q;
  logic [IW:0]    num_q;
  logic [1:0]     seq_q;
  logic [CNTW-1:0] cnt_q;
  logic           clearing_q;
  logic [PAW-1:0] clr_q;

  // datapath
  logic [31:0]    quot_q;
  logic [16:0]    rem_q;
  logic [16:0]    rem_sh;
  logic           rem_ge;

  // memories
  logic [IW-1:0]  pair_mem [PDEP];
  logic [31:0]    store_mem [MAX_EVENTS];
  logic [IW-1:0]  pair_rd_q;
  logic [31:0]    store_rd_q;
  logic [PAW-1:0] pair_addr, pair_waddr;
  logic [IW-1:0]  pair_wdata;
  logic           pair_we, store_we;

  // output register
  logic           out_valid_q;
  logic [1:0]     o_kind_q;
  logic [11:0]    o_idx_q;
  logic [31:0]    o_pos_q, o_itv_q, o_len_q;
  logic [4:0]     o_ch_q;
  logic [7:0]     o_key_q, o_vel_q;

  logic        accept, is_rel, ev_valid, hit, full, out_free, fin_go;
  logic [4:0]  ch;
  logic [7:0]  b;
  logic [31:0] used_inc, delta_new;

  assign b         = s_axis_tdata;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (seq_q == SqIdle) && !clearing_q;

  // event decode from held status and key
  assign is_rel   = status_q <= StatusPressLo;
  assign ch       = is_rel ? 5'(status_q - StatusRelLo) : 5'(status_q - StatusPressLo);
  assign ev_valid = (status_q >= StatusRelLo) && (status_q <= StatusHi) &&
                    ({1'b0, key_q} < 9'(NUM_KEYS));
  assign pair_addr = PAW'(ch) * PAW'(NUM_KEYS) + PAW'(key_q);
  assign hit       = pair_rd_q != '0;
  assign full      = num_q >= (IW+1)'(MAX_EVENTS);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign fin_go    = (seq_q == SqFin) && out_free;
  assign used_inc  = used_q + 32'd1;
  assign delta_new = (delta_q << 7) + {25'd0, b[6:0]};

  // divider step
  assign rem_sh = {rem_q[15:0], quot_q[31]};
  assign rem_ge = rem_sh >= {1'b0, tbase_q};

  // memory write control
  always_comb begin
    pair_we    = 1'b0;
    pair_waddr = pair_addr;
    pair_wdata = num_q[IW-1:0];
    store_we   = 1'b0;
    if (clearing_q) begin
      pair_we    = 1'b1;
      pair_waddr = clr_q;
      pair_wdata = '0;
    end else if (fin_go) begin
      if (is_rel) begin
        pair_we    = hit;
        pair_wdata = '0;
      end else begin
        pair_we  = !full;
        store_we = !full;
      end
    end
  end

  // pairing table memory
  always_ff @(posedge clk_i) begin
    if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
    pair_rd_q <= pair_mem[pair_addr];
  end

  // event start store memory
  always_ff @(posedge clk_i) begin
    if (store_we) store_mem[num_q[IW-1:0]] <= quot_q;
    store_rd_q <= store_mem[pair_rd_q];
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= TicksPerBeatRst;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + PAW'(1);
      if (clr_q == PAW'(PDEP - 1)) clearing_q <= 1'b0;
    end
  end

  // parser and event sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdrSkip;
      pcnt_q   <= '0;
      tracks_q <= '0;
      tbase_q  <= '0;
      tlen_q   <= '0;
      used_q   <= '0;
      delta_q  <= '0;
      abs_q    <= '0;
      status_q <= '0;
      key_q    <= '0;
      vel_q    <= '0;
      num_q    <= (IW+1)'(1);
      last_q   <= '0;
      seq_q    <= SqIdle;
      cnt_q    <= '0;
    end else begin
      case (seq_q)
        SqIdle: begin
          if (accept) begin
            case (phase_q)
              PhHdrSkip: begin
                pcnt_q <= pcnt_q + 4'd1;
                if (pcnt_q == 4'd9) begin
                  phase_q <= PhNtrk;
                  pcnt_q  <= '0;
                end
              end
              PhNtrk: begin
                tracks_q <= {tracks_q[7:0], b};
                pcnt_q   <= pcnt_q + 4'd1;
                if (pcnt_q == 4'd1) begin
                  phase_q <= PhTbase;
                  pcnt_q  <= '0;
                end
              end
              PhTbase: begin
                tbase_q <= {tbase_q[7:0], b};
                pcnt_q  <= pcnt_q + 4'd1;
                if (pcnt_q == 4'd1) begin
                  phase_q <= (tracks_q == '0) ? PhDone : PhTrkSkip;
                  pcnt_q  <= '0;
                end
              end
              PhTrkSkip: begin
                pcnt_q <= pcnt_q + 4'd1;
                if (pcnt_q == 4'd3) begin
                  phase_q <= PhTrkLen;
                  pcnt_q  <= '0;
                  tlen_q  <= '0;
                end
              end
              PhTrkLen: begin
                tlen_q <= {tlen_q[23:0], b};
                pcnt_q <= pcnt_q + 4'd1;
                if (pcnt_q == 4'd3) begin
                  pcnt_q <= '0;
                  used_q <= '0;
                  // used is zero here, so an event starts if length >= 1
                  if ({tlen_q[23:0], b} != 32'd0) begin
                    phase_q <= PhDelta;
                    delta_q <= '0;
                  end else begin
                    tracks_q <= tracks_q - 16'd1;
                    phase_q  <= (tracks_q == 16'd1) ? PhDone : PhTrkSkip;
                  end
                end
              end
              PhDelta: begin
                delta_q <= delta_new;
                used_q  <= used_inc;
                if (!b[7]) begin
                  abs_q   <= abs_q + delta_new;
                  phase_q <= PhStatus;
                end
              end
              PhStatus: begin
                status_q <= b;
                used_q   <= used_inc;
                phase_q  <= PhKey;
              end
              PhKey: begin
                key_q   <= b;
                used_q  <= used_inc;
                phase_q <= PhVel;
              end
              PhVel: begin
                vel_q  <= b;
                used_q <= used_inc;
                if (ev_valid) begin
                  seq_q <= SqMul;
                end else if (used_q + 32'd2 <= tlen_q) begin
                  phase_q <= PhDelta;
                  delta_q <= '0;
                end else begin
                  tracks_q <= tracks_q - 16'd1;
                  phase_q  <= (tracks_q == 16'd1) ? PhDone : PhTrkSkip;
                  pcnt_q   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        SqMul: begin
          seq_q <= SqDiv;
          cnt_q <= '0;
        end
        SqDiv: begin
          cnt_q <= cnt_q + CNTW'(1);
          if (cnt_q == CNTW'(DivBits - 1)) seq_q <= SqFin;
        end
        SqFin: begin
          if (out_free) begin
            seq_q <= SqIdle;
            if (!is_rel && !full) begin
              last_q <= quot_q;
              num_q  <= num_q + (IW+1)'(1);
            end
            if (used_inc <= tlen_q) begin
              phase_q <= PhDelta;
              delta_q <= '0;
            end else begin
              tracks_q <= tracks_q - 16'd1;
              phase_q  <= (tracks_q == 16'd1) ? PhDone : PhTrkSkip;
              pcnt_q   <= '0;
            end
          end
        end
        default: seq_q <= SqIdle;
      endcase
    end
  end

  // scale multiply and serial restoring divide
  always_ff @(posedge clk_i) begin
    if (seq_q == SqMul) begin
      quot_q <= 32'(abs_q * {16'd0, scale_q});
      rem_q  <= '0;
    end else if (seq_q == SqDiv) begin
      rem_q  <= rem_ge ? (rem_sh - {1'b0, tbase_q}) : rem_sh;
      quot_q <= {quot_q[30:0], rem_ge};
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      o_pos_q <= quot_q;
      o_ch_q  <= ch;
      o_key_q <= key_q;
      o_vel_q <= vel_q;
      o_itv_q <= '0;
      o_len_q <= '0;
      o_idx_q <= '0;
      if (is_rel) begin
        o_kind_q <= hit ? KindLength : KindNoPress;
        if (hit) begin
          o_idx_q <= 12'(pair_rd_q);
          o_len_q <= quot_q - store_rd_q;
        end
      end else begin
        o_kind_q <= full ? KindFull : KindStart;
        if (!full) begin
          o_idx_q <= 12'(num_q);
          o_itv_q <= quot_q - last_q;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tdata  = {7'd0, o_vel_q, o_key_q, o_ch_q, o_len_q, o_itv_q, o_pos_q,
                          o_idx_q};

  // checks
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s_axis_tready) else $error("byte taken during clearing pass");

  a_busy_on_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SqIdle) |-> (phase_q == PhVel)) else $error("sequencer busy off velocity");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (out_valid_q && (seq_q == SqIdle))) else $error("finish did not load beat");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SqMul) |=> (seq_q == SqDiv && cnt_q == '0)) else $error("divider not started");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI file note pairing parser core. It builds
// a MIDI byte stream: a directed header and two tracks, then random tracks of
// note events. A byte-level model predicts every result beat, and each beat
// is compared field by field. Both stream sides idle at random. The scale
// register is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import mfnp_pkg::*;

  // small event store so that the store-full case is reached
  localparam int unsigned MaxEv   = 32;
  localparam int unsigned EvW     = $clog2(MaxEv);
  localparam int unsigned NKeys   = NumKeysDef;
  localparam int unsigned CycLimit = 600000;

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] idx;
    logic [31:0] pos;
    logic [31:0] itv;
    logic [31:0] len;
    logic [4:0]  ch;
    logic [7:0]  key;
    logic [7:0]  vel;
  } note_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       chk;
    logic [1:0] kind;
  } dir_row_t;

  typedef struct {
    bit          is_cfg;
    logic [15:0] cfg;
    logic [7:0]  b;
    bit          chk;
    logic [1:0]  kind;
  } step_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [15:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;   // event_index, position, interval, note_length,
                                // channel, key, velocity
  logic [1:0]   m_axis_tuser;   // kind

  midi_file_note_pairing_parser_core #(
    .MAX_EVENTS(MaxEv),
    .NUM_KEYS  (NKeys)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser model state
  logic [15:0] scale_q;
  logic [3:0]  phase_q;
  int unsigned phase_cnt;
  logic [15:0] tracks_left;
  logic [15:0] timebase;
  logic [31:0] trk_len;
  logic [31:0] trk_used;
  logic [31:0] delta_acc;
  logic [31:0] abs_ticks;
  logic [7:0]  status_q;
  logic [7:0]  key_q;
  logic [11:0] pair_tbl [NumChanRows][NKeys];
  logic [31:0] start_pos [MaxEv];
  logic [12:0] next_num;
  logic [31:0] last_start;

  note_res_t   notes_due[$];
  step_t       byte_q[$];
  int          errors = 0;
  int          n_got = 0;
  int unsigned cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [31:0] scaled_pos();
    logic [63:0] prod;
    prod = {32'd0, abs_ticks} * {48'd0, scale_q};
    if (timebase == 16'd0) return 32'hFFFF_FFFF;
    return prod[31:0] / {16'd0, timebase};
  endfunction

  task automatic track_done();
    tracks_left = tracks_left - 16'd1;
    phase_q     = (tracks_left == 16'd0) ? PhDone : PhTrkSkip;
    phase_cnt   = 0;
  endtask

  task automatic event_or_track_end();
    logic [31:0] nxt;
    nxt = trk_used + 32'd1;
    if (nxt <= trk_len) begin
      phase_q   = PhDelta;
      delta_acc = '0;
    end else begin
      track_done();
    end
  endtask

  // note pairing on the velocity byte
  task automatic close_event(input logic [7:0] vel, output bit made, output note_res_t r);
    logic [11:0] idx;
    logic [4:0]  ch;
    made = 1'b0;
    r    = '{default: '0};
    if (status_q >= StatusRelLo && status_q <= StatusHi && key_q < NKeys) begin
      made  = 1'b1;
      r.pos = scaled_pos();
      r.key = key_q;
      r.vel = vel;
      if (status_q <= StatusPressLo) begin
        ch   = 5'(status_q - StatusRelLo);
        r.ch = ch;
        idx  = pair_tbl[ch][key_q];
        if (idx == 12'd0 || idx >= MaxEv) begin
          r.kind = KindNoPress;
        end else begin
          r.kind = KindLength;
          r.idx  = idx;
          r.len  = r.pos - start_pos[idx[EvW-1:0]];
          pair_tbl[ch][key_q] = 12'd0;
        end
      end else begin
        ch   = 5'(status_q - StatusPressLo);
        r.ch = ch;
        if (next_num >= MaxEv) begin
          r.kind = KindFull;
        end else begin
          r.kind = KindStart;
          r.idx  = next_num[11:0];
          r.itv  = r.pos - last_start;
          pair_tbl[ch][key_q] = next_num[11:0];
          start_pos[next_num[EvW-1:0]] = r.pos;
          last_start = r.pos;
          next_num   = next_num + 13'd1;
        end
      end
    end
    event_or_track_end();
  endtask

  // advance the model by one file byte
  task automatic parse_byte(input logic [7:0] b, output bit made, output note_res_t r);
    made = 1'b0;
    r    = '{default: '0};
    case (phase_q)
      PhHdrSkip: begin
        phase_cnt++;
        if (phase_cnt >= 10) begin
          phase_q = PhNtrk;
          phase_cnt = 0;
        end
      end
      PhNtrk: begin
        tracks_left = {tracks_left[7:0], b};
        phase_cnt++;
        if (phase_cnt >= 2) begin
          phase_q = PhTbase;
          phase_cnt = 0;
        end
      end
      PhTbase: begin
        timebase = {timebase[7:0], b};
        phase_cnt++;
        if (phase_cnt >= 2) begin
          phase_q = (tracks_left == 16'd0) ? PhDone : PhTrkSkip;
          phase_cnt = 0;
        end
      end
      PhTrkSkip: begin
        phase_cnt++;
        if (phase_cnt >= 4) begin
          phase_q = PhTrkLen;
          phase_cnt = 0;
          trk_len = '0;
        end
      end
      PhTrkLen: begin
        trk_len = {trk_len[23:0], b};
        phase_cnt++;
        if (phase_cnt >= 4) begin
          phase_cnt = 0;
          trk_used = '0;
          event_or_track_end();
        end
      end
      PhDelta: begin
        delta_acc = {delta_acc[24:0], 7'd0} + {25'd0, b[6:0]};
        trk_used++;
        if (!b[7]) begin
          abs_ticks = abs_ticks + delta_acc;
          phase_q = PhStatus;
        end
      end
      PhStatus: begin
        status_q = b;
        trk_used++;
        phase_q = PhKey;
      end
      PhKey: begin
        key_q = b;
        trk_used++;
        phase_q = PhVel;
      end
      PhVel: begin
        trk_used++;
        close_event(b, made, r);
      end
      default: ;
    endcase
  endtask

  // directed file: header, an empty track, then one short track
  dir_row_t dir_rows [] = '{
    '{8'h4D, 1'b0, KindStart}, '{8'h54, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    '{8'hFF, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    '{8'h00, 1'b0, KindStart}, '{8'h06, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    '{8'h01, 1'b0, KindStart},
    // track count and timebase, filled in once the stream is built
    '{8'h00, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    '{8'h00, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    // empty track
    '{8'h4D, 1'b0, KindStart}, '{8'h54, 1'b0, KindStart}, '{8'h72, 1'b0, KindStart},
    '{8'h6B, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    '{8'h00, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    // track of 25 bytes
    '{8'hFF, 1'b0, KindStart}, '{8'hFF, 1'b0, KindStart}, '{8'hFF, 1'b0, KindStart},
    '{8'hFF, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    '{8'h00, 1'b0, KindStart}, '{8'h19, 1'b0, KindStart},
    // release with no open press
    '{8'h00, 1'b0, KindStart}, '{8'h80, 1'b0, KindStart}, '{8'h05, 1'b0, KindStart},
    '{8'h40, 1'b1, KindNoPress},
    // two-byte delta, press on channel 1, top key
    '{8'h81, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart}, '{8'h91, 1'b0, KindStart},
    '{8'hFF, 1'b0, KindStart}, '{8'h7F, 1'b1, KindStart},
    // press on channel 16, then its release
    '{8'h7F, 1'b0, KindStart}, '{8'hA0, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    '{8'hFF, 1'b1, KindStart},
    '{8'h00, 1'b0, KindStart}, '{8'h90, 1'b0, KindStart}, '{8'h00, 1'b0, KindStart},
    '{8'h00, 1'b1, KindLength},
    // status bytes outside the note range are skipped
    '{8'h00, 1'b0, KindStart}, '{8'h05, 1'b0, KindStart}, '{8'h10, 1'b0, KindStart},
    '{8'h20, 1'b0, KindStart},
    '{8'h00, 1'b0, KindStart}, '{8'hA1, 1'b0, KindStart}, '{8'h10, 1'b0, KindStart},
    '{8'h20, 1'b0, KindStart}
  };

  function automatic step_t byte_step(input logic [7:0] b);
    step_t s;
    s = '{is_cfg: 1'b0, cfg: '0, b: b, chk: 1'b0, kind: KindStart};
    return s;
  endfunction

  function automatic step_t cfg_step(input logic [15:0] v);
    step_t s;
    s = '{is_cfg: 1'b1, cfg: v, b: '0, chk: 1'b0, kind: KindStart};
    return s;
  endfunction

  // one random track of mostly well-formed note events
  task automatic add_track(output int unsigned n_bytes);
    logic [7:0]  ev[$];
    logic [31:0] len;
    int unsigned n_ev;
    int unsigned r;
    int unsigned ch;
    n_ev = $urandom_range(1, 8);
    for (int e = 0; e < n_ev; e++) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        ev.push_back(8'($urandom_range(0, 15)));
      end else if (r < 18) begin
        ev.push_back(8'h80 | 8'($urandom_range(0, 127)));
        ev.push_back(8'($urandom_range(0, 127)));
      end else begin
        // long delta that wraps the accumulator
        repeat (4) ev.push_back(8'hFF);
        ev.push_back(8'($urandom_range(0, 127)));
      end
      r  = $urandom_range(0, 2);
      ch = (r == 0) ? 1 : (r == 1) ? 2 : 16;
      r  = $urandom_range(0, 19);
      if (r < 9) ev.push_back(StatusPressLo + 8'(ch));
      else if (r < 17) ev.push_back(StatusRelLo + 8'(ch));
      else ev.push_back(8'($urandom));
      ev.push_back(($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom));
      ev.push_back(8'($urandom));
    end
    len = ev.size();
    r = $urandom_range(0, 9);
    if (r == 0) len = len - 32'd1;
    else if (r == 1) len = len - 32'd2;
    repeat (4) byte_q.push_back(byte_step(8'($urandom)));
    for (int i = 3; i >= 0; i--) byte_q.push_back(byte_step(len[8*i +: 8]));
    foreach (ev[i]) byte_q.push_back(byte_step(ev[i]));
    n_bytes = ev.size() + 8;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[midi_file_note_pairing_parser_core] ERROR");
      $finish;
    end
  end

  // result side: random ready, one long hold-off, field compare
  initial begin
    note_res_t want;
    logic [1:0] g_kind;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        g_kind = m_axis_tuser;
        if (notes_due.size() == 0) begin
          report_mismatch("unexpected beat kind", 32'(g_kind), 32'd0);
        end else begin
          want = notes_due.pop_front();
          if (g_kind != want.kind) report_mismatch("kind", 32'(g_kind), 32'(want.kind));
          if (m_axis_tdata[11:0] != want.idx)
            report_mismatch("event_index", 32'(m_axis_tdata[11:0]), 32'(want.idx));
          if (m_axis_tdata[43:12] != want.pos)
            report_mismatch("position", m_axis_tdata[43:12], want.pos);
          if (m_axis_tdata[75:44] != want.itv)
            report_mismatch("interval", m_axis_tdata[75:44], want.itv);
          if (m_axis_tdata[107:76] != want.len)
            report_mismatch("note_length", m_axis_tdata[107:76], want.len);
          if (m_axis_tdata[112:108] != want.ch)
            report_mismatch("channel", 32'(m_axis_tdata[112:108]), 32'(want.ch));
          if (m_axis_tdata[120:113] != want.key)
            report_mismatch("key", 32'(m_axis_tdata[120:113]), 32'(want.key));
          if (m_axis_tdata[128:121] != want.vel)
            report_mismatch("velocity", 32'(m_axis_tdata[128:121]), 32'(want.vel));
          if (m_axis_tdata[135:129] != '0)
            report_mismatch("pad bits", 32'(m_axis_tdata[135:129]), 32'd0);
        end
        n_got++;
        if (n_got == 20) begin
          // long stall so the core backs up onto its input
          m_axis_tready <= 1'b0;
          repeat (3000) @(posedge clk_i);
        end
      end
      m_axis_tready <= ($urandom_range(0, 3) != 0) || (gap_len() == 0);
    end
  end

  // stream build, reset, byte driver
  initial begin
    step_t       st;
    bit          made;
    note_res_t   r;
    int unsigned base;
    int unsigned rnd_bytes;
    int unsigned nb;
    int unsigned n_trk;
    logic [15:0] tb_val;
    int unsigned g;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;

    // model reset
    scale_q = TicksPerBeatRst;
    phase_q = PhHdrSkip;
    phase_cnt = 0;
    tracks_left = '0;
    timebase = '0;
    trk_len = '0;
    trk_used = '0;
    delta_acc = '0;
    abs_ticks = '0;
    status_q = '0;
    key_q = '0;
    foreach (pair_tbl[c, k]) pair_tbl[c][k] = '0;
    next_num = 13'd1;
    last_start = '0;

    // build the whole stream first so the track count is known
    byte_q.push_back(cfg_step(16'($urandom_range(2, 65534))));
    base = byte_q.size();
    foreach (dir_rows[i])
      byte_q.push_back('{is_cfg: 1'b0, cfg: '0, b: dir_rows[i].b,
                         chk: dir_rows[i].chk, kind: dir_rows[i].kind});
    byte_q.push_back(cfg_step(16'd1));
    rnd_bytes = 0;
    n_trk = 2;
    while (rnd_bytes < 340) begin
      if (rnd_bytes >= 150 && rnd_bytes < 170) byte_q.push_back(cfg_step(16'($urandom)));
      if (rnd_bytes >= 280 && rnd_bytes < 300) byte_q.push_back(cfg_step(16'hFFFF));
      add_track(nb);
      rnd_bytes += nb;
      n_trk++;
    end
    // bytes after the last track are ignored
    repeat (6) byte_q.push_back(byte_step(8'($urandom)));
    tb_val = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    byte_q[base + 10].b = 8'(n_trk >> 8);
    byte_q[base + 11].b = 8'(n_trk);
    byte_q[base + 12].b = tb_val[15:8];
    byte_q[base + 13].b = tb_val[7:0];

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (byte_q[i]) begin
      st = byte_q[i];
      if (st.is_cfg) begin
        // core must be idle: drain results, then let a velocity byte finish
        s_axis_tvalid <= 1'b0;
        while (notes_due.size() != 0) @(posedge clk_i);
        repeat (60) @(posedge clk_i);
        cfg_we_i <= 1'b1;
        cfg_wdata_i <= st.cfg;
        @(posedge clk_i);
        scale_q = st.cfg;
        cfg_we_i <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= st.b;
        do @(posedge clk_i); while (!s_axis_tready);
        parse_byte(st.b, made, r);
        if (made) notes_due.push_back(r);
        if (st.chk && (!made || r.kind != st.kind))
          report_mismatch("directed kind", 32'(r.kind), 32'(st.kind));
        g = gap_len();
        if (g != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (notes_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("[midi_file_note_pairing_parser_core] OK");
    end else begin
      $display("[midi_file_note_pairing_parser_core] ERROR");
    end
    $finish;
  end

endmodule
